@@ rtl/hbtg_pkg.sv @@
// ----------------------------------------------------------------------------
// hbtg_pkg
// Shared types, widths and constants of the haptic buzz tone generator.
// ----------------------------------------------------------------------------
package hbtg_pkg;

    localparam int KIND_W    = 3;
    localparam int FACTOR_W  = 16;
    localparam int SPEED_W   = 16;
    localparam int TIME_W    = 32;
    localparam int BUZZ_W    = 24;
    localparam int AMP_W     = 23;
    localparam int PHASE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [FACTOR_W-1:0]  factor_t;
    typedef logic [SPEED_W-1:0]   speed_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [BUZZ_W-1:0]    buzz_t;
    typedef logic [AMP_W-1:0]     amp_t;
    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [CFG_W-1:0]     cfg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // warning kinds
    localparam kind_t KIND_NONE    = 3'd0;
    localparam kind_t KIND_DEBUG   = 3'd1;
    localparam kind_t KIND_SENSORS = 3'd2;

    // register indexes
    localparam cfg_idx_t CFG_PHASE_STEP    = 2'd0;
    localparam cfg_idx_t CFG_BEEP_RATE     = 2'd1;
    localparam cfg_idx_t CFG_BASE_STRENGTH = 2'd2;
    localparam cfg_idx_t CFG_SPEED_GAIN    = 2'd3;

    localparam cfg_t BEEP_RATE_RESET = 16'd256;

    localparam amp_t AMP_STEP_LIMIT = 23'd640;
    localparam amp_t AMP_MAX        = 23'h7FFFFF;

    // shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef logic [MUL_A_W-1:0] mul_a_t;
    typedef logic [MUL_B_W-1:0] mul_b_t;
    typedef logic [MUL_P_W-1:0] mul_p_t;

    // sine denominator and divider: 20 * 2^47 / d, d in [4 * 2^32, 5 * 2^32]
    localparam int DEN_W   = 35;
    localparam int QUOT_W  = 18;
    localparam int DCNT_W  = 5;
    localparam int WAVE_W  = 15;

    typedef logic [DEN_W-1:0]  den_t;
    typedef logic [QUOT_W-1:0] quot_t;
    typedef logic [WAVE_W-1:0] wave_t;

    localparam den_t DEN_BASE     = den_t'(5) << 32;
    localparam den_t DIV_INIT_REM = den_t'(5) << 31;
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(QUOT_W);

    localparam phase_t HALF_TURN = 16'h8000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/hbtg_in_if.sv @@
// ----------------------------------------------------------------------------
// hbtg_in_if
// Tick channel: warning kind, factor, motor speed and time per control tick.
// ----------------------------------------------------------------------------
interface hbtg_in_if;

    logic                    valid;
    logic                    ready;
    hbtg_pkg::kind_t         warning_kind;
    hbtg_pkg::factor_t       warning_factor;
    logic signed [15:0]      motor_speed;
    hbtg_pkg::time_t         tick_time;

    modport source (
        output valid,
        output warning_kind,
        output warning_factor,
        output motor_speed,
        output tick_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  warning_kind,
        input  warning_factor,
        input  motor_speed,
        input  tick_time,
        output ready
    );

endinterface

@@ rtl/hbtg_out_if.sv @@
// ----------------------------------------------------------------------------
// hbtg_out_if
// Result channel: signed buzz current and the rate-limited amplitude.
// ----------------------------------------------------------------------------
interface hbtg_out_if;

    logic                    valid;
    logic                    ready;
    logic signed [23:0]      buzz_level;
    hbtg_pkg::amp_t          amplitude_now;

    modport source (
        output valid,
        output buzz_level,
        output amplitude_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  buzz_level,
        input  amplitude_now,
        output ready
    );

endinterface

@@ rtl/haptic_buzz_tone_generator.sv @@
// ----------------------------------------------------------------------------
// haptic_buzz_tone_generator
// Phase-accumulator buzz oscillator with a Bhaskara sine, beep gating and a
// rate-limited amplitude, sequenced over one shared multiplier and divider.
//
//   channel  dir  handshake          payload
//   tick     in   valid / ready      warning_kind, warning_factor,
//                                    motor_speed, tick_time
//   buzz     out  valid / ready      buzz_level, amplitude_now
//   cfg      in   cfg_we             cfg_index, cfg_wdata
//
// A tick with non-zero amplitude runs the sine, the 18-step divider and the
// scaling on the shared multiplier; a silent one goes straight to the result.
// One tick is worked on at a time; tick.ready is low until the result is
// handed to the output register, which holds it while buzz.ready is low.
// Reset clears amplitude, phase and registers (beep_rate to 256).
// ----------------------------------------------------------------------------
module haptic_buzz_tone_generator
(
    input  logic                 clk,
    input  logic                 rst_n,
    hbtg_in_if.sink              tick,
    hbtg_out_if.source           buzz,
    input  logic                 cfg_we,
    input  hbtg_pkg::cfg_idx_t   cfg_index,
    input  hbtg_pkg::cfg_t       cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BEEP,
        S_SPEED,
        S_STRENGTH,
        S_TARGET,
        S_RAMP,
        S_STEP,
        S_PHASE,
        S_SINE,
        S_DEN,
        S_DIV,
        S_WAVE,
        S_SCALE,
        S_OUT,
        S_DONE
    } state_t;

    state_t                  state_reg;

    hbtg_pkg::cfg_t          phase_step_reg;
    hbtg_pkg::cfg_t          beep_rate_reg;
    hbtg_pkg::cfg_t          base_strength_reg;
    hbtg_pkg::cfg_t          speed_gain_reg;

    hbtg_pkg::kind_t         kind_reg;
    hbtg_pkg::factor_t       factor_reg;
    logic [16:0]             mag_speed_reg;
    logic [23:0]             now_reg;
    logic                    on_reg;
    logic [32:0]             strength_reg;
    hbtg_pkg::amp_t          target_reg;
    hbtg_pkg::amp_t          amplitude_reg;
    hbtg_pkg::phase_t        phase_reg;
    logic                    second_reg;
    hbtg_pkg::wave_t         wave_reg;
    hbtg_pkg::buzz_t         result_reg;

    logic                    out_valid_reg;
    hbtg_pkg::buzz_t         out_buzz_reg;
    hbtg_pkg::amp_t          out_amp_reg;

    hbtg_pkg::mul_a_t        mul_a;
    hbtg_pkg::mul_b_t        mul_b;
    hbtg_pkg::mul_p_t        prod;

    logic                    div_start;
    hbtg_pkg::den_t          div_den;
    hbtg_pkg::quot_t         quot;
    hbtg_pkg::div_stat_t     div_stat;

    logic [16:0]             speed_mag;
    logic                    second;
    hbtg_pkg::phase_t        sine_x;
    hbtg_pkg::phase_t        sine_y;
    hbtg_pkg::amp_t          amp_diff;
    hbtg_pkg::amp_t          amp_move;
    logic                    ramp_up;
    hbtg_pkg::amp_t          scaled;
    logic                    out_free;

    hbtg_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hbtg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .quot  (quot),
        .stat  (div_stat)
    );

    assign speed_mag = tick.motor_speed[15] ? 17'(17'h10000 - {1'b0, tick.motor_speed})
                                            : {1'b0, tick.motor_speed};

    assign second = phase_reg[15] && (|phase_reg[14:0]);
    assign sine_x = second ? {1'b0, phase_reg[14:0]} : phase_reg;
    assign sine_y = hbtg_pkg::HALF_TURN - sine_x;

    assign ramp_up  = target_reg > amplitude_reg;
    assign amp_diff = ramp_up ? target_reg - amplitude_reg : amplitude_reg - target_reg;
    assign amp_move = (amp_diff > hbtg_pkg::AMP_STEP_LIMIT) ? hbtg_pkg::AMP_STEP_LIMIT
                                                            : amp_diff;

    assign scaled   = prod[37:15];
    assign out_free = !out_valid_reg || buzz.ready;

    assign div_start = (state_reg == S_DEN);
    assign div_den   = hbtg_pkg::DEN_BASE - hbtg_pkg::DEN_W'({prod[28:0], 4'b0000});

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_BEEP:
            begin
                mul_a = hbtg_pkg::MUL_A_W'(now_reg);
                mul_b = hbtg_pkg::MUL_B_W'(beep_rate_reg);
            end
            S_SPEED:
            begin
                mul_a = hbtg_pkg::MUL_A_W'(mag_speed_reg);
                mul_b = hbtg_pkg::MUL_B_W'(speed_gain_reg);
            end
            S_TARGET:
            begin
                mul_a = strength_reg;
                mul_b = hbtg_pkg::MUL_B_W'(factor_reg);
            end
            S_SINE:
            begin
                mul_a = hbtg_pkg::MUL_A_W'(sine_x);
                mul_b = hbtg_pkg::MUL_B_W'(sine_y);
            end
            S_SCALE:
            begin
                mul_a = hbtg_pkg::MUL_A_W'(amplitude_reg);
                mul_b = hbtg_pkg::MUL_B_W'(wave_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            phase_step_reg    <= '0;
            beep_rate_reg     <= hbtg_pkg::BEEP_RATE_RESET;
            base_strength_reg <= '0;
            speed_gain_reg    <= '0;
            kind_reg          <= '0;
            factor_reg        <= '0;
            mag_speed_reg     <= '0;
            now_reg           <= '0;
            on_reg            <= 1'b0;
            strength_reg      <= '0;
            target_reg        <= '0;
            amplitude_reg     <= '0;
            phase_reg         <= '0;
            second_reg        <= 1'b0;
            wave_reg          <= '0;
            result_reg        <= '0;
            out_valid_reg     <= 1'b0;
            out_buzz_reg      <= '0;
            out_amp_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hbtg_pkg::CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata;
                    hbtg_pkg::CFG_BEEP_RATE:     beep_rate_reg     <= cfg_wdata;
                    hbtg_pkg::CFG_BASE_STRENGTH: base_strength_reg <= cfg_wdata;
                    hbtg_pkg::CFG_SPEED_GAIN:    speed_gain_reg    <= cfg_wdata;
                    default:                     phase_step_reg    <= phase_step_reg;
                endcase
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (buzz.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (tick.valid)
                    begin
                        kind_reg      <= tick.warning_kind;
                        factor_reg    <= tick.warning_factor;
                        mag_speed_reg <= speed_mag;
                        now_reg       <= tick.tick_time[23:0];
                        state_reg     <= S_BEEP;
                    end
                end
                S_BEEP:
                begin
                    state_reg <= S_SPEED;
                end
                S_SPEED:
                begin
                    // beep square wave from bit 23 of time times rate
                    on_reg    <= (kind_reg != hbtg_pkg::KIND_NONE) &&
                                 ((kind_reg inside {hbtg_pkg::KIND_DEBUG,
                                                    hbtg_pkg::KIND_SENSORS}) || !prod[23]);
                    state_reg <= S_STRENGTH;
                end
                S_STRENGTH:
                begin
                    strength_reg <= {9'b0, base_strength_reg, 8'b0} + prod[32:0];
                    state_reg    <= S_TARGET;
                end
                S_TARGET:
                begin
                    state_reg <= S_RAMP;
                end
                S_RAMP:
                begin
                    if (!on_reg)
                        target_reg <= '0;
                    else if (|prod[48:39])
                        target_reg <= hbtg_pkg::AMP_MAX;
                    else
                        target_reg <= prod[38:16];
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    amplitude_reg <= ramp_up ? amplitude_reg + amp_move
                                             : amplitude_reg - amp_move;
                    state_reg     <= S_PHASE;
                end
                S_PHASE:
                begin
                    if (amplitude_reg == '0)
                    begin
                        result_reg <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + phase_step_reg;
                        state_reg <= S_SINE;
                    end
                end
                S_SINE:
                begin
                    second_reg <= second;
                    state_reg  <= S_DEN;
                end
                S_DEN:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_WAVE;
                    end
                end
                S_WAVE:
                begin
                    if (!quot[17])
                        wave_reg <= '0;
                    else if (|quot[16:15])
                        wave_reg <= '1;
                    else
                        wave_reg <= quot[14:0];
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    result_reg <= second_reg ? hbtg_pkg::BUZZ_W'(24'd0 - {1'b0, scaled})
                                             : {1'b0, scaled};
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_buzz_reg  <= result_reg;
                        out_amp_reg   <= amplitude_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tick.ready         = (state_reg == S_IDLE);
    assign buzz.valid         = out_valid_reg;
    assign buzz.buzz_level    = out_buzz_reg;
    assign buzz.amplitude_now = out_amp_reg;

endmodule

@@ rtl/hbtg_mul.sv @@
// ----------------------------------------------------------------------------
// hbtg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module hbtg_mul
(
    input  logic              clk,
    input  hbtg_pkg::mul_a_t  a,
    input  hbtg_pkg::mul_b_t  b,
    output hbtg_pkg::mul_p_t  prod
);

    hbtg_pkg::mul_p_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= hbtg_pkg::MUL_P_W'(a) * hbtg_pkg::MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/hbtg_div.sv @@
// ----------------------------------------------------------------------------
// hbtg_div
// Restoring divider for the sine approximation: 20 * 2^47 / den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbtg_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hbtg_pkg::den_t       den,
    output hbtg_pkg::quot_t      quot,
    output hbtg_pkg::div_stat_t  stat
);

    hbtg_pkg::den_t                 den_reg;
    hbtg_pkg::den_t                 rem_reg;
    hbtg_pkg::quot_t                quot_reg;
    logic [hbtg_pkg::DCNT_W-1:0]    count_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [hbtg_pkg::DEN_W:0]       rem_shift;
    logic                           fits;

    // the dividend has only zero bits below the initial window
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= hbtg_pkg::DIV_STEPS;
                den_reg   <= den;
                rem_reg   <= hbtg_pkg::DIV_INIT_REM;
                quot_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg   <= fits ? hbtg_pkg::DEN_W'(rem_shift - {1'b0, den_reg})
                                  : rem_shift[hbtg_pkg::DEN_W-1:0];
                quot_reg  <= {quot_reg[hbtg_pkg::QUOT_W-2:0], fits};
                count_reg <= count_reg - 1'b1;
                if (count_reg == hbtg_pkg::DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ test/haptic_buzz_tone_generator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haptic_buzz_tone_generator_test
// Self-checking bench for the buzz tone generator. A queue-fed driver sends
// control ticks, a monitor predicts each buzz result from its own copy of
// amplitude, phase and registers and compares it with the DUT output.
// Directed ticks cover gating, kinds and field extremes. Random phases then
// change the registers and apply several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module haptic_buzz_tone_generator_test;

    localparam hbtg_pkg::kind_t KIND_DUTY  = 3'd3;
    localparam hbtg_pkg::kind_t KIND_OTHER = 3'd4;
    localparam hbtg_pkg::kind_t KIND_RSVD5 = 3'd5;
    localparam hbtg_pkg::kind_t KIND_RSVD7 = 3'd7;

    localparam int QUIET_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 158;

    typedef struct packed {
        hbtg_pkg::kind_t   kind;
        hbtg_pkg::factor_t factor;
        hbtg_pkg::speed_t  speed;
        hbtg_pkg::time_t   now;
    } tick_item_t;

    typedef struct packed {
        hbtg_pkg::buzz_t buzz;
        hbtg_pkg::amp_t  amp;
    } buzz_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    hbtg_pkg::cfg_idx_t cfg_index;
    hbtg_pkg::cfg_t cfg_wdata;

    hbtg_in_if  tick_ch ();
    hbtg_out_if buzz_ch ();

    haptic_buzz_tone_generator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .buzz      (buzz_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and register copies
    hbtg_pkg::cfg_t   step_cfg;
    hbtg_pkg::cfg_t   beep_cfg;
    hbtg_pkg::cfg_t   base_cfg;
    hbtg_pkg::cfg_t   gain_cfg;
    hbtg_pkg::amp_t   amp_state;
    hbtg_pkg::phase_t phase_state;

    tick_item_t   tick_pending[$];
    buzz_result_t buzz_expected[$];
    tick_item_t   next_tick;
    tick_item_t   seen_tick;
    buzz_result_t want;

    int src_idle_pct;
    int sink_stall_pct;
    int n_errors;
    int quiet_cycles;
    logic [31:0] clock_now;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic hbtg_pkg::wave_t sine_mag(input hbtg_pkg::phase_t x);
        logic [63:0] xx;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] m;
        xx = {48'd0, x};
        d = 64'd16 * xx * xx + (64'd5 << 32) - 64'd8 * xx * 64'd65536;
        q = (64'd20 << 47) / d;
        m = (q >= 64'd131072) ? q - 64'd131072 : 64'd0;
        if (m > 64'd32767)
        begin
            m = 64'd32767;
        end
        return m[14:0];
    endfunction

    function automatic buzz_result_t predict_buzz(input tick_item_t t);
        logic        gate_on;
        logic        second;
        logic [63:0] prod;
        logic [63:0] mag_speed;
        logic [63:0] strength;
        logic [63:0] target;
        logic [63:0] a;
        logic [63:0] diff;
        logic [63:0] limit;
        logic [63:0] mag;
        logic [63:0] signed_mag;
        hbtg_pkg::phase_t x;
        buzz_result_t r;
        limit = {41'd0, hbtg_pkg::AMP_STEP_LIMIT};
        if (t.kind == hbtg_pkg::KIND_NONE)
        begin
            gate_on = 1'b0;
        end
        else if (t.kind == hbtg_pkg::KIND_DEBUG || t.kind == hbtg_pkg::KIND_SENSORS)
        begin
            gate_on = 1'b1;
        end
        else
        begin
            prod = {32'd0, t.now} * {48'd0, beep_cfg};
            gate_on = ~prod[23];
        end
        mag_speed = t.speed[15] ? (64'h10000 - {48'd0, t.speed}) : {48'd0, t.speed};
        target = 64'd0;
        if (gate_on)
        begin
            strength = ({48'd0, base_cfg} << 8) + mag_speed * {48'd0, gain_cfg};
            target = (strength * {48'd0, t.factor}) >> 16;
            if (target > {41'd0, hbtg_pkg::AMP_MAX})
            begin
                target = {41'd0, hbtg_pkg::AMP_MAX};
            end
        end
        a = {41'd0, amp_state};
        if (target > a)
        begin
            diff = target - a;
            a = a + ((diff > limit) ? limit : diff);
        end
        else
        begin
            diff = a - target;
            a = a - ((diff > limit) ? limit : diff);
        end
        a = a & {41'd0, hbtg_pkg::AMP_MAX};
        amp_state = a[22:0];
        r.amp = a[22:0];
        r.buzz = '0;
        if (a != 64'd0)
        begin
            phase_state = phase_state + step_cfg;
            second = phase_state > hbtg_pkg::HALF_TURN;
            x = second ? phase_state - hbtg_pkg::HALF_TURN : phase_state;
            mag = ({49'd0, sine_mag(x)} * a) >> 15;
            signed_mag = second ? (64'd0 - mag) : mag;
            r.buzz = signed_mag[23:0];
        end
        return r;
    endfunction

    function automatic hbtg_pkg::cfg_t pick_cfg_value();
        logic [31:0] r;
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default:
            begin
                r = $urandom_range(65535);
                return hbtg_pkg::cfg_t'(r >> $urandom_range(15));
            end
        endcase
    endfunction

    task automatic push_tick(input hbtg_pkg::kind_t k, input hbtg_pkg::factor_t f,
                             input hbtg_pkg::speed_t s, input hbtg_pkg::time_t n);
        tick_item_t t;
        t.kind = k;
        t.factor = f;
        t.speed = s;
        t.now = n;
        tick_pending.push_back(t);
    endtask

    task automatic queue_random_ticks(input int n);
        tick_item_t      t;
        int              run_left;
        hbtg_pkg::kind_t run_kind;
        logic [31:0]     stride;
        run_left = 0;
        run_kind = hbtg_pkg::KIND_DEBUG;
        stride = $urandom_range(4096, 1);
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(60, 1);
                case ($urandom_range(9))
                    0, 1:    run_kind = hbtg_pkg::KIND_NONE;
                    2:       run_kind = hbtg_pkg::KIND_DEBUG;
                    3, 4:    run_kind = hbtg_pkg::KIND_SENSORS;
                    5, 6:    run_kind = KIND_DUTY;
                    7, 8:    run_kind = KIND_OTHER;
                    default: run_kind = hbtg_pkg::kind_t'($urandom_range(7, 5));
                endcase
            end
            run_left--;
            t.kind = ($urandom_range(19) == 0) ? hbtg_pkg::kind_t'($urandom_range(7))
                                               : run_kind;
            case ($urandom_range(9))
                0:       t.factor = 16'h0000;
                1:       t.factor = 16'hFFFF;
                2:       t.factor = hbtg_pkg::factor_t'($urandom_range(65535)
                                                        >> $urandom_range(15));
                default: t.factor = hbtg_pkg::factor_t'($urandom_range(65535));
            endcase
            case ($urandom_range(9))
                0:       t.speed = 16'h8000;
                1:       t.speed = 16'h7FFF;
                2:       t.speed = hbtg_pkg::speed_t'($urandom_range(65535)
                                                      >> $urandom_range(15));
                default: t.speed = hbtg_pkg::speed_t'($urandom_range(65535));
            endcase
            clock_now = clock_now + stride;
            t.now = ($urandom_range(9) < 7) ? clock_now : $urandom;
            tick_pending.push_back(t);
        end
    endtask

    task automatic write_reg(input hbtg_pkg::cfg_idx_t idx, input hbtg_pkg::cfg_t val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            hbtg_pkg::CFG_PHASE_STEP:    step_cfg = val;
            hbtg_pkg::CFG_BEEP_RATE:     beep_cfg = val;
            hbtg_pkg::CFG_BASE_STRENGTH: base_cfg = val;
            hbtg_pkg::CFG_SPEED_GAIN:    gain_cfg = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (tick_pending.size() != 0 || tick_ch.valid || buzz_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_idling(input int src, input int sink);
        src_idle_pct = src;
        sink_stall_pct = sink;
    endtask

    // driver: next transaction once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
        end
        else if (!tick_ch.valid || tick_ch.ready)
        begin
            if (tick_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_tick = tick_pending.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.warning_kind <= next_tick.kind;
                tick_ch.warning_factor <= next_tick.factor;
                tick_ch.motor_speed <= next_tick.speed;
                tick_ch.tick_time <= next_tick.now;
            end
            else
            begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            buzz_ch.ready <= 1'b0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                seen_tick.kind = tick_ch.warning_kind;
                seen_tick.factor = tick_ch.warning_factor;
                seen_tick.speed = tick_ch.motor_speed;
                seen_tick.now = tick_ch.tick_time;
                buzz_expected.push_back(predict_buzz(seen_tick));
            end
            if (buzz_ch.valid && buzz_ch.ready)
            begin
                if (buzz_expected.size() == 0)
                begin
                    if (n_errors < 10)
                    begin
                        $display("unexpected result: buzz %0d amp %0d",
                                 buzz_ch.buzz_level, buzz_ch.amplitude_now);
                    end
                    n_errors++;
                end
                else
                begin
                    want = buzz_expected.pop_front();
                    if (hbtg_pkg::buzz_t'(buzz_ch.buzz_level) !== want.buzz
                        || buzz_ch.amplitude_now !== want.amp)
                    begin
                        if (n_errors < 10)
                        begin
                            $display("mismatch: buzz exp %0d got %0d, amp exp %0d got %0d",
                                     $signed(want.buzz), buzz_ch.buzz_level,
                                     want.amp, buzz_ch.amplitude_now);
                        end
                        n_errors++;
                    end
                end
            end
            if ((tick_ch.valid && tick_ch.ready) || (buzz_ch.valid && buzz_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            buzz_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = hbtg_pkg::CFG_PHASE_STEP;
        cfg_wdata = '0;
        tick_ch.valid = 1'b0;
        tick_ch.warning_kind = hbtg_pkg::KIND_NONE;
        tick_ch.warning_factor = '0;
        tick_ch.motor_speed = '0;
        tick_ch.tick_time = '0;
        buzz_ch.ready = 1'b0;
        step_cfg = '0;
        beep_cfg = hbtg_pkg::BEEP_RATE_RESET;
        base_cfg = '0;
        gain_cfg = '0;
        amp_state = '0;
        phase_state = '0;
        n_errors = 0;
        quiet_cycles = 0;
        clock_now = '0;
        set_idling(0, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values
        push_tick(hbtg_pkg::KIND_DEBUG, 16'hFFFF, 16'h8000, 32'h0000_0000);
        push_tick(KIND_DUTY, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF);
        push_tick(hbtg_pkg::KIND_NONE, 16'hFFFF, 16'h7FFF, 32'h0000_0000);
        wait_drained();

        write_reg(hbtg_pkg::CFG_PHASE_STEP, 16'h4000);
        write_reg(hbtg_pkg::CFG_BEEP_RATE, hbtg_pkg::BEEP_RATE_RESET);
        write_reg(hbtg_pkg::CFG_BASE_STRENGTH, 16'h0400);
        write_reg(hbtg_pkg::CFG_SPEED_GAIN, 16'h0100);
        end_writes();

        push_tick(hbtg_pkg::KIND_NONE, 16'hFFFF, 16'h7FFF, 32'h0000_0000);
        push_tick(hbtg_pkg::KIND_DEBUG, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF);
        push_tick(hbtg_pkg::KIND_SENSORS, 16'h0000, 16'h0000, 32'h0000_0000);
        push_tick(KIND_DUTY, 16'h0100, 16'h0000, 32'h0000_0000);
        push_tick(KIND_DUTY, 16'h0100, 16'h0000, 32'h0000_8000);
        push_tick(KIND_OTHER, 16'h0100, 16'hFFFF, 32'h0000_7FFF);
        push_tick(KIND_RSVD5, 16'hFFFF, 16'h0001, 32'h0000_0000);
        push_tick(KIND_RSVD7, 16'hFFFF, 16'h0001, 32'h0000_8000);
        // climb through every quarter turn
        for (int i = 0; i < 6; i++)
        begin
            push_tick(hbtg_pkg::KIND_DEBUG, 16'hFFFF, 16'h8000, 32'h0000_0000);
        end
        push_tick(hbtg_pkg::KIND_SENSORS, 16'h0080, 16'h7FFF, 32'h1234_5678);
        push_tick(hbtg_pkg::KIND_NONE, 16'h0000, 16'h8000, 32'h0000_0000);
        push_tick(hbtg_pkg::KIND_NONE, 16'h0000, 16'h8000, 32'h0000_0000);
        push_tick(KIND_DUTY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_tick(KIND_OTHER, 16'hFFFF, 16'h8000, 32'h0000_7FFF);
        push_tick(KIND_RSVD7, 16'h0001, 16'h0000, 32'h8000_0000);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(61, 0);
                2:       set_idling(0, 61);
                default: set_idling(38, 38);
            endcase
            if (p == 0)
            begin
                write_reg(hbtg_pkg::CFG_PHASE_STEP, 16'hFFFF);
                write_reg(hbtg_pkg::CFG_BEEP_RATE, 16'hFFFF);
                write_reg(hbtg_pkg::CFG_BASE_STRENGTH, 16'hFFFF);
                write_reg(hbtg_pkg::CFG_SPEED_GAIN, 16'hFFFF);
            end
            else if (p == 1)
            begin
                write_reg(hbtg_pkg::CFG_PHASE_STEP, 16'h0000);
                write_reg(hbtg_pkg::CFG_BEEP_RATE, 16'h0000);
                write_reg(hbtg_pkg::CFG_BASE_STRENGTH, 16'h0000);
                write_reg(hbtg_pkg::CFG_SPEED_GAIN, 16'h0000);
            end
            else
            begin
                write_reg(hbtg_pkg::CFG_PHASE_STEP, pick_cfg_value());
                write_reg(hbtg_pkg::CFG_BEEP_RATE, pick_cfg_value());
                write_reg(hbtg_pkg::CFG_BASE_STRENGTH, pick_cfg_value());
                write_reg(hbtg_pkg::CFG_SPEED_GAIN, pick_cfg_value());
            end
            end_writes();
            queue_random_ticks(TICKS_PER_PHASE);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hbtg_pkg.sv
rtl/hbtg_in_if.sv
rtl/hbtg_out_if.sv
rtl/hbtg_mul.sv
rtl/hbtg_div.sv
rtl/haptic_buzz_tone_generator.sv
test/haptic_buzz_tone_generator_test.sv
